/* rtl/assert_macros.svh */
// Assertion shorthands shared by the checker files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Consequent checked in the same cycle as the antecedent.
`define PFDE_ASSERT_NOW(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Consequent checked in the cycle after the antecedent.
`define PFDE_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

/* rtl/pfde_pkg.sv */
package pfde_pkg;

   // default panel geometry
   localparam int PANEL_WIDTH_DEF = 96;
   localparam int PANEL_PAGES_DEF = 4;

   // width of a byte address before trimming to the store depth
   // (32 pages x 256 columns at most)
   localparam int ADDR_CALC_W = 14;

   typedef enum logic [2:0] {
      FUNC_POINT = 3'd0,
      FUNC_LINE  = 3'd1,
      FUNC_RECT  = 3'd2,
      FUNC_CLEAR = 3'd3,
      FUNC_READ  = 3'd4
   } func_type;

   typedef enum logic [6:0] {
      ST_INIT  = 7'b0000001,
      ST_IDLE  = 7'b0000010,
      ST_DRAW  = 7'b0000100,
      ST_DRAIN = 7'b0001000,
      ST_CLEAR = 7'b0010000,
      ST_READ  = 7'b0100000,
      ST_RESP  = 7'b1000000
   } state_type;

endpackage

/* rtl/page_framebuffer_draw_engine.sv */
// Page-layout monochrome frame store with a small draw engine.
// Pixel (x,y) lives in byte (y/8)*PANEL_WIDTH + x under mask 0x80 >> (y%8).
// Request channel (req_*): one command per request - set/clear a point, draw a
// line, fill an inclusive rectangle, clear every byte to a pattern, read a byte.
// Response channel (rsp_*): exactly one response per request, in order;
// rsp_read_data is the addressed byte for an in-range read, zero otherwise.
// Commands run one at a time. A line walks one pixel per cycle over dist+2
// pixels with dist = max(|dx|,|dy|), a point is a single pixel, and a
// rectangle walks one whole page byte per cycle; an empty one draws nothing.
// The rate is set by the single read-modify-write path through the frame
// memory: one read port, one write port, one byte touched per cycle; a
// byte read in the same cycle as it is written is forwarded.
// Reset: synchronous, active high. Afterwards a clearing pass writes zero to
// all DEPTH bytes with req_ready low.
// The response sits in an output register; while the receiver stalls the
// block still takes and executes the next request, and holds that one's
// response until the output register frees.
module page_framebuffer_draw_engine
   import pfde_pkg::*;
#(
   parameter int PANEL_WIDTH = PANEL_WIDTH_DEF,
   parameter int PANEL_PAGES = PANEL_PAGES_DEF
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  logic [2:0] req_func,
   input  logic [7:0] req_x_a,
   input  logic [7:0] req_y_a,
   input  logic [7:0] req_x_b,
   input  logic [7:0] req_y_b,
   input  logic       req_color,
   input  logic [7:0] req_fill_byte,
   input  logic [8:0] req_read_index,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output logic [7:0] rsp_read_data
);

   localparam int DEPTH  = PANEL_WIDTH * PANEL_PAGES;
   localparam int ADDR_W = $clog2(DEPTH);
   localparam logic [7:0] X_MAX = 8'(PANEL_WIDTH - 1);
   localparam logic [7:0] Y_MAX = 8'(PANEL_PAGES * 8 - 1);
   localparam logic signed [9:0] W_S = 10'(PANEL_WIDTH);
   localparam logic signed [9:0] H_S = 10'(PANEL_PAGES * 8);
   localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(DEPTH - 1);

   state_type state_ff, state_in;

   // command
   logic       rect_mode_ff, rect_mode_in;
   logic       color_ff, color_in;
   logic [7:0] fill_ff, fill_in;
   logic       rd_ok_ff, rd_ok_in;
   logic [7:0] res_ff, res_in;

   // line walker
   logic signed [9:0] px_ff, px_in, py_ff, py_in;
   logic [8:0] ex_ff, ex_in, ey_ff, ey_in;
   logic [7:0] adx_ff, adx_in, ady_ff, ady_in, dist_ff, dist_in;
   logic       sx_neg_ff, sx_neg_in, sy_neg_ff, sy_neg_in;
   logic [8:0] t_ff, t_in, lim_ff, lim_in;

   // rectangle walker, one page byte per step
   logic [7:0] cx_ff, cx_in, x0_ff, x0_in, x1_ff, x1_in;
   logic [4:0] pg_ff, pg_in, pg_first_ff, pg_first_in, pg_last_ff, pg_last_in;
   logic [2:0] lo0_ff, lo0_in, hi_last_ff, hi_last_in;

   // clearing sweep
   logic [ADDR_W-1:0] sweep_ff, sweep_in;

   // read-modify-write pipe
   logic              s2_valid_ff, s2_valid_in;
   logic [ADDR_W-1:0] s2_addr_ff, s2_addr_in;
   logic [7:0]        s2_mask_ff, s2_mask_in;
   logic              wr_valid_ff, wr_valid_in;
   logic [ADDR_W-1:0] wr_addr_ff, wr_addr_in;
   logic [7:0]        wr_data_ff, wr_data_in;

   // output register
   logic       rsp_valid_ff, rsp_valid_in;
   logic [7:0] rsp_data_ff, rsp_data_in;

   // memory port
   logic              ram_wr_en;
   logic [ADDR_W-1:0] ram_wr_addr, ram_rd_addr;
   logic [7:0]        ram_wr_data, ram_rd_data;

   logic req_fire;
   logic signed [8:0] dx9, dy9;
   logic [7:0] adx_req, ady_req, dist_req, x1c_req, y1c_req;
   logic [ADDR_CALC_W-1:0] ridx_wide;

   logic       pix_ok, pix_last;
   logic [7:0] pix_x, pix_mask;
   logic [4:0] pix_pg;
   logic [2:0] row_lo, row_hi;
   logic [ADDR_CALC_W-1:0] pix_addr_wide;
   logic [8:0] ex_sum, ey_sum;
   logic [7:0] rmw_base, rmw_new;
   logic       out_free;

   pfde_ram #(
      .WIDTH (8),
      .DEPTH (DEPTH)
   ) u_store (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   assign req_ready = (state_ff == ST_IDLE);
   assign req_fire  = req_valid && req_ready;
   assign out_free  = !rsp_valid_ff || rsp_ready;

   // request set-up terms
   assign dx9 = 9'({1'b0, req_x_b}) - 9'({1'b0, req_x_a});
   assign dy9 = 9'({1'b0, req_y_b}) - 9'({1'b0, req_y_a});
   assign adx_req  = dx9[8] ? 8'(-dx9) : dx9[7:0];
   assign ady_req  = dy9[8] ? 8'(-dy9) : dy9[7:0];
   assign dist_req = (adx_req > ady_req) ? adx_req : ady_req;
   assign x1c_req  = (req_x_b > X_MAX) ? X_MAX : req_x_b;
   assign y1c_req  = (req_y_b > Y_MAX) ? Y_MAX : req_y_b;
   assign ridx_wide = ADDR_CALC_W'(req_read_index);

   // current pixel / page byte
   assign row_lo = (pg_ff == pg_first_ff) ? lo0_ff : 3'd0;
   assign row_hi = (pg_ff == pg_last_ff) ? hi_last_ff : 3'd7;

   always_comb begin
      if (rect_mode_ff) begin
         pix_ok   = 1'b1;
         pix_x    = cx_ff;
         pix_pg   = pg_ff;
         pix_mask = (8'hFF >> row_lo) & (8'hFF << (3'd7 - row_hi));
         pix_last = (cx_ff == x1_ff) && (pg_ff == pg_last_ff);
      end else begin
         // off-panel points, including a step past zero or 255, are dropped
         pix_ok   = (px_ff >= 10'sd0) && (px_ff < W_S) &&
                    (py_ff >= 10'sd0) && (py_ff < H_S);
         pix_x    = px_ff[7:0];
         pix_pg   = py_ff[7:3];
         pix_mask = 8'h80 >> py_ff[2:0];
         pix_last = (t_ff == lim_ff);
      end
   end

   assign pix_addr_wide = ADDR_CALC_W'(pix_pg) * ADDR_CALC_W'(PANEL_WIDTH) +
                          ADDR_CALC_W'(pix_x);

   // error accumulators, strict greater-than
   assign ex_sum = ex_ff + 9'(adx_ff);
   assign ey_sum = ey_ff + 9'(ady_ff);

   // modify stage, forwarding the byte written in the previous cycle
   assign rmw_base = (wr_valid_ff && (wr_addr_ff == s2_addr_ff)) ? wr_data_ff
                                                                  : ram_rd_data;
   assign rmw_new  = color_ff ? (rmw_base | s2_mask_ff) : (rmw_base & ~s2_mask_ff);

   assign ram_rd_addr = (state_ff == ST_DRAW) ? pix_addr_wide[ADDR_W-1:0]
                                              : ridx_wide[ADDR_W-1:0];

   always_comb begin
      if (s2_valid_ff) begin
         ram_wr_en   = 1'b1;
         ram_wr_addr = s2_addr_ff;
         ram_wr_data = rmw_new;
      end else begin
         ram_wr_en   = (state_ff == ST_INIT) || (state_ff == ST_CLEAR);
         ram_wr_addr = sweep_ff;
         ram_wr_data = (state_ff == ST_INIT) ? 8'h00 : fill_ff;
      end
   end

   always_comb begin
      state_in     = state_ff;
      rect_mode_in = rect_mode_ff;
      color_in     = color_ff;
      fill_in      = fill_ff;
      rd_ok_in     = rd_ok_ff;
      res_in       = res_ff;
      px_in        = px_ff;
      py_in        = py_ff;
      ex_in        = ex_ff;
      ey_in        = ey_ff;
      adx_in       = adx_ff;
      ady_in       = ady_ff;
      dist_in      = dist_ff;
      sx_neg_in    = sx_neg_ff;
      sy_neg_in    = sy_neg_ff;
      t_in         = t_ff;
      lim_in       = lim_ff;
      cx_in        = cx_ff;
      x0_in        = x0_ff;
      x1_in        = x1_ff;
      pg_in        = pg_ff;
      pg_first_in  = pg_first_ff;
      pg_last_in   = pg_last_ff;
      lo0_in       = lo0_ff;
      hi_last_in   = hi_last_ff;
      sweep_in     = sweep_ff;
      s2_valid_in  = 1'b0;
      s2_addr_in   = pix_addr_wide[ADDR_W-1:0];
      s2_mask_in   = pix_mask;
      wr_valid_in  = s2_valid_ff;
      wr_addr_in   = s2_addr_ff;
      wr_data_in   = rmw_new;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_data_in  = rsp_data_ff;

      unique case (state_ff)
         ST_INIT: begin
            sweep_in = sweep_ff + 1'b1;
            if (sweep_ff == LAST_ADDR) begin
               sweep_in = '0;
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (req_fire) begin
               color_in     = req_color;
               fill_in      = req_fill_byte;
               rd_ok_in     = ridx_wide < ADDR_CALC_W'(DEPTH);
               res_in       = 8'h00;
               rect_mode_in = 1'b0;
               // line set-up; a point is a line with no length
               px_in     = 10'({2'b00, req_x_a});
               py_in     = 10'({2'b00, req_y_a});
               ex_in     = '0;
               ey_in     = '0;
               t_in      = '0;
               sx_neg_in = dx9[8];
               sy_neg_in = dy9[8];
               // rectangle set-up, end clipped to the panel
               cx_in       = req_x_a;
               x0_in       = req_x_a;
               x1_in       = x1c_req;
               pg_in       = req_y_a[7:3];
               pg_first_in = req_y_a[7:3];
               pg_last_in  = y1c_req[7:3];
               lo0_in      = req_y_a[2:0];
               hi_last_in  = y1c_req[2:0];
               unique case (req_func)
                  FUNC_POINT: begin
                     adx_in   = '0;
                     ady_in   = '0;
                     dist_in  = '0;
                     lim_in   = '0;
                     state_in = ST_DRAW;
                  end
                  FUNC_LINE: begin
                     adx_in   = adx_req;
                     ady_in   = ady_req;
                     dist_in  = dist_req;
                     lim_in   = 9'({1'b0, dist_req}) + 9'd1;
                     state_in = ST_DRAW;
                  end
                  FUNC_RECT: begin
                     rect_mode_in = 1'b1;
                     if ((req_x_a > x1c_req) || (req_y_a > y1c_req)) begin
                        state_in = ST_RESP;
                     end else begin
                        state_in = ST_DRAW;
                     end
                  end
                  FUNC_CLEAR: begin
                     sweep_in = '0;
                     state_in = ST_CLEAR;
                  end
                  FUNC_READ: begin
                     state_in = ST_READ;
                  end
                  default: begin
                     state_in = ST_RESP;
                  end
               endcase
            end
         end
         ST_DRAW: begin
            s2_valid_in = pix_ok;
            if (rect_mode_ff) begin
               if (cx_ff == x1_ff) begin
                  cx_in = x0_ff;
                  pg_in = pg_ff + 1'b1;
               end else begin
                  cx_in = cx_ff + 1'b1;
               end
            end else begin
               t_in  = t_ff + 1'b1;
               ex_in = ex_sum;
               ey_in = ey_sum;
               if (ex_sum > 9'(dist_ff)) begin
                  ex_in = ex_sum - 9'(dist_ff);
                  px_in = sx_neg_ff ? px_ff - 10'sd1 : px_ff + 10'sd1;
               end
               if (ey_sum > 9'(dist_ff)) begin
                  ey_in = ey_sum - 9'(dist_ff);
                  py_in = sy_neg_ff ? py_ff - 10'sd1 : py_ff + 10'sd1;
               end
            end
            if (pix_last) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            // last modify/write lands this cycle
            state_in = ST_RESP;
         end
         ST_CLEAR: begin
            sweep_in = sweep_ff + 1'b1;
            if (sweep_ff == LAST_ADDR) begin
               sweep_in = '0;
               state_in = ST_RESP;
            end
         end
         ST_READ: begin
            res_in   = rd_ok_ff ? ram_rd_data : 8'h00;
            state_in = ST_RESP;
         end
         ST_RESP: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = res_ff;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_INIT;
         sweep_ff     <= '0;
         s2_valid_ff  <= 1'b0;
         wr_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         sweep_ff     <= sweep_in;
         s2_valid_ff  <= s2_valid_in;
         wr_valid_ff  <= wr_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rect_mode_ff <= rect_mode_in;
      color_ff     <= color_in;
      fill_ff      <= fill_in;
      rd_ok_ff     <= rd_ok_in;
      res_ff       <= res_in;
      px_ff        <= px_in;
      py_ff        <= py_in;
      ex_ff        <= ex_in;
      ey_ff        <= ey_in;
      adx_ff       <= adx_in;
      ady_ff       <= ady_in;
      dist_ff      <= dist_in;
      sx_neg_ff    <= sx_neg_in;
      sy_neg_ff    <= sy_neg_in;
      t_ff         <= t_in;
      lim_ff       <= lim_in;
      cx_ff        <= cx_in;
      x0_ff        <= x0_in;
      x1_ff        <= x1_in;
      pg_ff        <= pg_in;
      pg_first_ff  <= pg_first_in;
      pg_last_ff   <= pg_last_in;
      lo0_ff       <= lo0_in;
      hi_last_ff   <= hi_last_in;
      s2_addr_ff   <= s2_addr_in;
      s2_mask_ff   <= s2_mask_in;
      wr_addr_ff   <= wr_addr_in;
      wr_data_ff   <= wr_data_in;
      rsp_data_ff  <= rsp_data_in;
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_read_data = rsp_data_ff;

endmodule

/* rtl/pfde_ram.sv */
module pfde_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 384
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // read returns the old contents on a same-address write
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

/* rtl/pfde_checker.sv */
`include "assert_macros.svh"

module pfde_checker (
   input logic       clock,
   input logic       reset,
   input logic       req_valid,
   input logic       req_ready,
   input logic       rsp_valid,
   input logic       rsp_ready,
   input logic [7:0] rsp_read_data
);

   // requests taken but not yet answered
   logic [1:0] pend_ff, pend_in;

   always_comb begin
      pend_in = pend_ff;
      if ((req_valid && req_ready) && !(rsp_valid && rsp_ready)) begin
         pend_in = pend_ff + 2'd1;
      end else if (!(req_valid && req_ready) && (rsp_valid && rsp_ready)) begin
         pend_in = pend_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pend_ff <= '0;
      end else begin
         pend_ff <= pend_in;
      end
   end

   `PFDE_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid, "response dropped while stalled")
   `PFDE_ASSERT_NEXT(a_rsp_stable, clock, reset, rsp_valid && !rsp_ready, $stable(rsp_read_data), "response data changed while stalled")
   `PFDE_ASSERT_NOW(a_rsp_owed, clock, reset, rsp_valid, pend_ff != 2'd0, "response without an open request")
   `PFDE_ASSERT_NOW(a_ready_room, clock, reset, req_ready, pend_ff <= 2'd1, "request taken with two already open")
   `PFDE_ASSERT_NOW(a_init_pass, clock, reset, $past(reset), !req_ready, "request taken during clearing pass")

endmodule

bind page_framebuffer_draw_engine pfde_checker u_pfde_checker (.*);

/* test/page_framebuffer_draw_engine_tb.sv */
`timescale 1ns / 1ps

module page_framebuffer_draw_engine_tb;
   import pfde_pkg::*;

   // Panel geometry at the default parameters of the block
   localparam int PANEL_W     = PANEL_WIDTH_DEF;
   localparam int PANEL_H     = PANEL_PAGES_DEF * 8;
   localparam int STORE_BYTES = PANEL_W * PANEL_PAGES_DEF;

   // Random phase length (requests that do real work) and how often the sender
   // stops to let every outstanding response come back
   localparam int RANDOM_REQS  = 610;
   localparam int DRAIN_EVERY  = 160;
   // Quiet time after the last response
   localparam int SETTLE_CYCLES = 400;
   localparam int PRINT_CAP     = 100;

   // func codes with no operation behind them
   localparam logic [2:0] FUNC_SPARE_LO  = 3'd5;
   localparam logic [2:0] FUNC_SPARE_HI  = 3'd7;

   typedef enum logic [1:0] {
      RX_OPEN,
      RX_COIN,
      RX_TRICKLE,
      RX_RUNS
   } rx_mode_type;

   typedef struct {
      logic [2:0] func;
      logic [7:0] x_a;
      logic [7:0] y_a;
      logic [7:0] x_b;
      logic [7:0] y_b;
      logic       color;
      logic [7:0] fill_byte;
      logic [8:0] read_index;
   } draw_cmd_type;

   // Directed row: pinned rows carry a hand-typed read_data
   typedef struct {
      draw_cmd_type cmd;
      bit           pinned;
      logic [7:0]   want;
   } script_row_type;

   typedef struct {
      logic [7:0] data;
      int         seq;
   } read_expect_type;

   // ------------------------------------------------------------------
   // DUT ports; every input has a known value from time zero
   // ------------------------------------------------------------------
   logic       clock;
   logic       reset          = 1'b1;
   logic       req_valid      = 1'b0;
   logic       req_ready;
   logic [2:0] req_func       = 3'd0;
   logic [7:0] req_x_a        = 8'h00;
   logic [7:0] req_y_a        = 8'h00;
   logic [7:0] req_x_b        = 8'h00;
   logic [7:0] req_y_b        = 8'h00;
   logic       req_color      = 1'b0;
   logic [7:0] req_fill_byte  = 8'h00;
   logic [8:0] req_read_index = 9'd0;
   logic       rsp_valid;
   logic       rsp_ready      = 1'b0;
   logic [7:0] rsp_read_data;

   page_framebuffer_draw_engine i_dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_func       (req_func),
      .req_x_a        (req_x_a),
      .req_y_a        (req_y_a),
      .req_x_b        (req_x_b),
      .req_y_b        (req_y_b),
      .req_color      (req_color),
      .req_fill_byte  (req_fill_byte),
      .req_read_index (req_read_index),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_read_data  (rsp_read_data)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   // Hard stop, several times the slowest legal run (all clears, full stalls)
   initial begin
      #(20_000_000);
      $display("== FAIL ==");
      $finish;
   end

   // ------------------------------------------------------------------
   // Shadow frame store: the expected contents, kept request by request
   // ------------------------------------------------------------------
   logic [7:0]      shadow_frame [STORE_BYTES];
   read_expect_type read_back_q [$];
   script_row_type  script_rows [$];
   int              error_count = 0;
   int              req_count   = 0;
   int              burst_left  = 0;

   task automatic flag_error(input string msg);
      if (error_count < PRINT_CAP)
         $display("%0t ns  mismatch: %s", $time, msg);
      error_count++;
   endtask

   // Off-panel pixels are dropped, negative coordinates included
   function automatic void plot_pixel(input int x, input int y, input logic color);
      int         idx;
      logic [7:0] mask;
      if (x < 0 || y < 0 || x >= PANEL_W || y >= PANEL_H)
         return;
      idx  = (y / 8) * PANEL_W + x;
      mask = 8'h80 >> (y % 8);
      if (color)
         shadow_frame[idx] = shadow_frame[idx] | mask;
      else
         shadow_frame[idx] = shadow_frame[idx] & ~mask;
   endfunction

   // Error-accumulator stepping, strict greater-than, span+2 points.
   // Coordinates stay int so a step past 255 or below 0 is dropped, not wrapped.
   function automatic void trace_line(input int x1, y1, x2, y2, input logic color);
      int dx, dy, sx, sy, span, ex, ey, px, py;
      dx = x2 - x1;
      dy = y2 - y1;
      sx = 0;
      sy = 0;
      ex = 0;
      ey = 0;
      px = x1;
      py = y1;
      if (dx > 0) begin
         sx = 1;
      end else if (dx < 0) begin
         sx = -1;
         dx = -dx;
      end
      if (dy > 0) begin
         sy = 1;
      end else if (dy < 0) begin
         sy = -1;
         dy = -dy;
      end
      span = (dx > dy) ? dx : dy;
      for (int t = 0; t <= span + 1; t++) begin
         plot_pixel(px, py, color);
         ex += dx;
         ey += dy;
         if (ex > span) begin
            ex -= span;
            px += sx;
         end
         if (ey > span) begin
            ey -= span;
            py += sy;
         end
      end
   endfunction

   // Inclusive box, end clipped to the panel; start beyond end draws nothing
   function automatic void fill_box(input int x0, y0, x1, y1, input logic color);
      int xe, ye;
      xe = (x1 > PANEL_W - 1) ? PANEL_W - 1 : x1;
      ye = (y1 > PANEL_H - 1) ? PANEL_H - 1 : y1;
      for (int y = y0; y <= ye; y++)
         for (int x = x0; x <= xe; x++)
            plot_pixel(x, y, color);
   endfunction

   // Applies one request to the shadow store and returns the read_data it yields
   function automatic logic [7:0] predict_read_data(input draw_cmd_type c);
      logic [7:0] data;
      data = 8'h00;
      case (c.func)
         FUNC_POINT: plot_pixel(int'(c.x_a), int'(c.y_a), c.color);
         FUNC_LINE:  trace_line(int'(c.x_a), int'(c.y_a), int'(c.x_b), int'(c.y_b),
                                c.color);
         FUNC_RECT:  fill_box(int'(c.x_a), int'(c.y_a), int'(c.x_b), int'(c.y_b),
                              c.color);
         FUNC_CLEAR: begin
            foreach (shadow_frame[i])
               shadow_frame[i] = c.fill_byte;
         end
         FUNC_READ: begin
            if (c.read_index < STORE_BYTES)
               data = shadow_frame[c.read_index];
         end
         default: ;
      endcase
      return data;
   endfunction

   // ------------------------------------------------------------------
   // Random request generation
   // ------------------------------------------------------------------

   // Mostly on the panel, some right at the edges, a few anywhere in 0..255
   function automatic logic [7:0] pick_coord(input int limit);
      int r;
      r = $urandom_range(0, 9);
      if (r < 7)
         return 8'($urandom_range(0, limit - 1));
      else if (r < 9)
         return 8'($urandom_range(limit - 3, limit + 2));
      else
         return 8'($urandom_range(0, 255));
   endfunction

   // base plus an offset in lo..hi, held inside the 8-bit field
   function automatic logic [7:0] offset_coord(input int base, input int lo, input int hi);
      int v;
      v = base + lo + int'($urandom_range(0, hi - lo));
      if (v < 0)
         v = 0;
      if (v > 255)
         v = 255;
      return 8'(v);
   endfunction

   function automatic draw_cmd_type random_command();
      draw_cmd_type c;
      int           pick;
      // fields the command does not use carry noise
      c.x_a        = 8'($urandom);
      c.y_a        = 8'($urandom);
      c.x_b        = 8'($urandom);
      c.y_b        = 8'($urandom);
      c.color      = 1'($urandom);
      c.fill_byte  = 8'($urandom);
      c.read_index = 9'($urandom);
      pick = $urandom_range(0, 99);
      if (pick < 26)
         c.func = FUNC_POINT;
      else if (pick < 52)
         c.func = FUNC_LINE;
      else if (pick < 67)
         c.func = FUNC_RECT;
      else if (pick < 93)
         c.func = FUNC_READ;
      else if (pick < 97)
         c.func = FUNC_CLEAR;
      else
         c.func = 3'($urandom_range(FUNC_SPARE_LO, FUNC_SPARE_HI));

      case (c.func)
         FUNC_POINT: begin
            c.x_a = pick_coord(PANEL_W);
            c.y_a = pick_coord(PANEL_H);
         end
         FUNC_LINE: begin
            c.x_a = pick_coord(PANEL_W);
            c.y_a = pick_coord(PANEL_H);
            // short strokes mostly; now and then a long one
            if ($urandom_range(0, 3) != 0) begin
               c.x_b = offset_coord(int'(c.x_a), -12, 12);
               c.y_b = offset_coord(int'(c.y_a), -12, 12);
            end else begin
               c.x_b = pick_coord(PANEL_W);
               c.y_b = pick_coord(PANEL_H);
            end
         end
         FUNC_RECT: begin
            c.x_a = pick_coord(PANEL_W);
            c.y_a = pick_coord(PANEL_H);
            // small boxes, sometimes inverted on an axis; now and then a big one
            if ($urandom_range(0, 9) != 0) begin
               c.x_b = offset_coord(int'(c.x_a), -2, 14);
               c.y_b = offset_coord(int'(c.y_a), -2, 10);
            end else begin
               c.x_b = pick_coord(PANEL_W);
               c.y_b = pick_coord(PANEL_H);
            end
         end
         FUNC_READ: begin
            if ($urandom_range(0, 9) != 0)
               c.read_index = 9'($urandom_range(0, STORE_BYTES - 1));
            else
               c.read_index = 9'($urandom_range(STORE_BYTES, 511));
         end
         default: ;
      endcase
      return c;
   endfunction

   // ------------------------------------------------------------------
   // Request driver: bursts of random length, random gaps between them
   // ------------------------------------------------------------------
   task automatic push_request(input draw_cmd_type c, input bit pinned,
                               input logic [7:0] want);
      read_expect_type e;
      int              gap;
      if (burst_left == 0) begin
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
         // valid only drops when a real gap follows, never lowered and raised
         // within one step
         if (gap > 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(60, 120)
                                                  : $urandom_range(1, 24);
      end
      req_valid      <= 1'b1;
      req_func       <= c.func;
      req_x_a        <= c.x_a;
      req_y_a        <= c.y_a;
      req_x_b        <= c.x_b;
      req_y_b        <= c.y_b;
      req_color      <= c.color;
      req_fill_byte  <= c.fill_byte;
      req_read_index <= c.read_index;
      do @(posedge clock); while (!req_ready);
      // accepted at this edge
      e.data = predict_read_data(c);
      if (pinned)
         e.data = want;
      e.seq = req_count;
      read_back_q.push_back(e);
      req_count++;
      burst_left--;
   endtask

   // Sender holds off until every outstanding response is back
   task automatic wait_all_answered();
      req_valid <= 1'b0;
      do @(posedge clock); while (read_back_q.size() != 0);
   endtask

   task automatic add_row(input logic [2:0] f, input logic [7:0] xa, ya, xb, yb,
                          input logic col, input logic [7:0] fill,
                          input logic [8:0] ridx, input bit pinned,
                          input logic [7:0] want);
      script_row_type r;
      r.cmd.func       = f;
      r.cmd.x_a        = xa;
      r.cmd.y_a        = ya;
      r.cmd.x_b        = xb;
      r.cmd.y_b        = yb;
      r.cmd.color      = col;
      r.cmd.fill_byte  = fill;
      r.cmd.read_index = ridx;
      r.pinned         = pinned;
      r.want           = want;
      script_rows.push_back(r);
   endtask

   // ------------------------------------------------------------------
   // Receiver: ready pattern switches between modes -
   // always open, coin toss, one in eight, or long on/off runs
   // ------------------------------------------------------------------
   rx_mode_type rx_mode   = RX_OPEN;
   int          rx_window = 0;
   int          rx_run    = 0;

   always @(posedge clock) begin
      if (rx_window == 0) begin
         rx_mode   <= rx_mode_type'($urandom_range(0, 3));
         rx_window <= $urandom_range(50, 400);
      end else begin
         rx_window <= rx_window - 1;
      end
      case (rx_mode)
         RX_OPEN:    rsp_ready <= 1'b1;
         RX_COIN:    rsp_ready <= 1'($urandom_range(0, 1));
         RX_TRICKLE: rsp_ready <= ($urandom_range(0, 7) == 0);
         default: begin
            if (rx_run == 0) begin
               rsp_ready <= ~rsp_ready;
               rx_run    <= $urandom_range(1, 30);
            end else begin
               rx_run <= rx_run - 1;
            end
         end
      endcase
   end

   // ------------------------------------------------------------------
   // Response checker: in order, against the oldest outstanding request
   // ------------------------------------------------------------------
   read_expect_type head;

   always @(posedge clock) begin
      if (!reset && rsp_valid === 1'b1 && rsp_ready) begin
         if (read_back_q.size() == 0) begin
            flag_error($sformatf("response 0x%02h with no request outstanding",
                                 rsp_read_data));
         end else begin
            head = read_back_q.pop_front();
            if (rsp_read_data !== head.data)
               flag_error($sformatf("request %0d: read_data 0x%02h, predicted 0x%02h",
                                    head.seq, rsp_read_data, head.data));
         end
      end
   end

   // ------------------------------------------------------------------
   // Stimulus
   // ------------------------------------------------------------------
   initial begin
      draw_cmd_type c;
      int           counted;
      int           since_drain;

      foreach (shadow_frame[i])
         shadow_frame[i] = 8'h00;

      // Directed rows.  Reads of a freshly reset store, the corner pixels,
      // off-panel and out-of-range cases and the unused codes have their
      // answer typed in; lines and boxes go through the shadow store.
      //      func           xa     ya     xb     yb     col   fill   ridx   pin   want
      add_row(FUNC_READ,     8'd0,  8'd0,  8'd0,  8'd0,  1'b0, 8'h00, 9'd0,   1'b1, 8'h00);
      add_row(FUNC_READ,     8'd0,  8'd0,  8'd0,  8'd0,  1'b0, 8'h00, 9'd383, 1'b1, 8'h00);
      add_row(FUNC_READ,     8'd0,  8'd0,  8'd0,  8'd0,  1'b0, 8'h00, 9'd511, 1'b1, 8'h00);
      add_row(FUNC_POINT,    8'd0,  8'd0,  8'd0,  8'd0,  1'b1, 8'h00, 9'd0,   1'b1, 8'h00);
      add_row(FUNC_READ,     8'd0,  8'd0,  8'd0,  8'd0,  1'b0, 8'h00, 9'd0,   1'b1, 8'h80);
      add_row(FUNC_POINT,    8'd95, 8'd31, 8'd0,  8'd0,  1'b1, 8'h00, 9'd0,   1'b1, 8'h00);
      add_row(FUNC_READ,     8'd0,  8'd0,  8'd0,  8'd0,  1'b0, 8'h00, 9'd383, 1'b1, 8'h01);
      // one past the right edge, then the far corner of the byte range
      add_row(FUNC_POINT,    8'd96, 8'd0,  8'd0,  8'd0,  1'b1, 8'h00, 9'd0,   1'b1, 8'h00);
      add_row(FUNC_POINT,    8'd255,8'd255,8'd0,  8'd0,  1'b1, 8'h00, 9'd0,   1'b1, 8'h00);
      add_row(FUNC_POINT,    8'd0,  8'd0,  8'd0,  8'd0,  1'b0, 8'h00, 9'd0,   1'b1, 8'h00);
      add_row(FUNC_READ,     8'd0,  8'd0,  8'd0,  8'd0,  1'b0, 8'h00, 9'd0,   1'b1, 8'h00);
      // diagonals both ways, full-range lines that run off the panel, a dot
      add_row(FUNC_LINE,     8'd0,  8'd0,  8'd95, 8'd31, 1'b1, 8'h00, 9'd0,   1'b0, 8'h00);
      add_row(FUNC_LINE,     8'd95, 8'd0,  8'd0,  8'd31, 1'b1, 8'h00, 9'd0,   1'b0, 8'h00);
      add_row(FUNC_LINE,     8'd255,8'd255,8'd0,  8'd0,  1'b0, 8'h00, 9'd0,   1'b0, 8'h00);
      add_row(FUNC_LINE,     8'd0,  8'd255,8'd255,8'd0,  1'b1, 8'h00, 9'd0,   1'b0, 8'h00);
      add_row(FUNC_LINE,     8'd10, 8'd10, 8'd10, 8'd10, 1'b1, 8'h00, 9'd0,   1'b0, 8'h00);
      add_row(FUNC_READ,     8'd0,  8'd0,  8'd0,  8'd0,  1'b0, 8'h00, 9'd106, 1'b0, 8'h00);
      // whole panel set, then an inverted box, then a cleared hole
      add_row(FUNC_RECT,     8'd0,  8'd0,  8'd255,8'd255,1'b1, 8'h00, 9'd0,   1'b0, 8'h00);
      add_row(FUNC_READ,     8'd0,  8'd0,  8'd0,  8'd0,  1'b0, 8'h00, 9'd200, 1'b1, 8'hFF);
      add_row(FUNC_RECT,     8'd50, 8'd5,  8'd40, 8'd20, 1'b0, 8'h00, 9'd0,   1'b0, 8'h00);
      add_row(FUNC_RECT,     8'd10, 8'd3,  8'd20, 8'd12, 1'b0, 8'h00, 9'd0,   1'b0, 8'h00);
      add_row(FUNC_READ,     8'd0,  8'd0,  8'd0,  8'd0,  1'b0, 8'h00, 9'd111, 1'b0, 8'h00);
      add_row(FUNC_CLEAR,    8'd0,  8'd0,  8'd0,  8'd0,  1'b0, 8'hA5, 9'd0,   1'b1, 8'h00);
      add_row(FUNC_READ,     8'd0,  8'd0,  8'd0,  8'd0,  1'b0, 8'h00, 9'd100, 1'b1, 8'hA5);
      // unused codes with busy fields: no change, zero back
      add_row(FUNC_SPARE_LO, 8'd1,  8'd1,  8'd90, 8'd30, 1'b1, 8'hFF, 9'd100, 1'b1, 8'h00);
      add_row(FUNC_SPARE_HI, 8'd0,  8'd0,  8'd95, 8'd31, 1'b0, 8'h00, 9'd100, 1'b1, 8'h00);

      // Single reset; the block then runs its clearing pass with req_ready low
      reset <= 1'b1;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      foreach (script_rows[i])
         push_request(script_rows[i].cmd, script_rows[i].pinned, script_rows[i].want);
      wait_all_answered();

      counted     = 0;
      since_drain = 0;
      while (counted < RANDOM_REQS) begin
         c = random_command();
         push_request(c, 1'b0, 8'h00);
         // unused codes do nothing in the block, so they do not count
         if (c.func <= FUNC_READ) begin
            counted++;
            since_drain++;
         end
         if (since_drain >= DRAIN_EVERY) begin
            wait_all_answered();
            since_drain = 0;
         end
      end

      wait_all_answered();
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (error_count == 0)
         $display("== PASS ==");
      else
         $display("== FAIL ==");
      $finish;
   end

endmodule
